FILE: hdl/rtuchk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtuchk_pkg
// Codes, constants and shared types of the RTU response checker.
// ----------------------------------------------------------------------------
package rtuchk_pkg;

  // input item function codes
  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_BYTE    = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  // result status codes
  localparam logic [1:0] ST_WORD    = 2'd0;
  localparam logic [1:0] ST_ACCEPT  = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_DEVICE_ADDR  = 3'd0;
  localparam logic [2:0] CFG_MODE         = 3'd1;
  localparam logic [2:0] CFG_REG_COUNT    = 3'd2;
  localparam logic [2:0] CFG_ECHO_ADDRESS = 3'd3;
  localparam logic [2:0] CFG_ECHO_VALUE   = 3'd4;

  // Modbus function codes and CRC-16 constants
  localparam logic [7:0]  FC_READ  = 8'h03;
  localparam logic [7:0]  FC_WRITE = 8'h06;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic clear;  // back to CRC_INIT
    logic load;   // fold in a byte and start the eight shift steps
  } crc_ctrl_t;

endpackage

FILE: hdl/rtuchk_crc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtuchk_crc
// Bit-serial CRC-16 accumulator, one shift step per cycle, eight per byte.
// ----------------------------------------------------------------------------
module rtuchk_crc (
  input  logic                  clk,
  input  logic                  rst,
  input  rtuchk_pkg::crc_ctrl_t ctrl,
  input  logic [7:0]            data,
  output logic [15:0]           crc,
  output logic                  busy
);

  logic [2:0] bit_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc     <= rtuchk_pkg::CRC_INIT;
      busy    <= 1'b0;
      bit_cnt <= 3'd0;
    end else if (ctrl.clear) begin
      crc  <= rtuchk_pkg::CRC_INIT;
      busy <= 1'b0;
    end else if (ctrl.load) begin
      crc     <= crc ^ {8'h00, data};
      busy    <= 1'b1;
      bit_cnt <= 3'd0;
    end else if (busy) begin
      crc     <= crc[0] ? ((crc >> 1) ^ rtuchk_pkg::CRC_POLY) : (crc >> 1);
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  a_eight_steps: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ##8 !busy)
    else $error("crc busy not eight cycles");

endmodule

FILE: hdl/rtuchk_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtuchk_store
// Register word store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rtuchk_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/rtu_response_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtu_response_checker
// Master-side Modbus RTU reply checker with bit-serial CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the
//    expected address, mode, register count and write echo; always ready.
//  - Input channel carries func (start, byte, timeout) and rx_byte.
//  - Output channel gives status, reg_index, reg_value and last; the verdict
//    of a run carries last.
//  - A checked byte is accepted, then the bit-serial CRC unit runs its eight
//    shift steps, and the checker returns to idle once it sees the unit finish.
//  - Start (but for a read with a bad count), the CRC low byte and ignored
//    requests stay idle; a verdict goes through accept, then verdict load.
//  - On a good read reply each word passes the fetch state (registered store
//    read) and the word state (output load), then the accepted verdict follows.
//  - If the receiver stalls, the block holds the result and does not take a
//    new item until that result has been loaded into the output register; one
//    finished result may wait there while the next item is taken.
//  - Reset clears the configuration to its defaults and leaves the checker
//    idle until a start item. The word store is not cleared.
// ----------------------------------------------------------------------------
module rtu_response_checker #(
  parameter int MAX_REGS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [4:0]  reg_index,
  output logic [15:0] reg_value,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CRC     = 5'b00010,
    S_FETCH   = 5'b00100,
    S_WORD    = 5'b01000,
    S_VERDICT = 5'b10000
  } state_t;

  state_t state;

  // configuration
  logic [7:0]  device_addr;
  logic        transaction_mode;
  logic [5:0]  reg_count;
  logic [15:0] echo_address;
  logic [15:0] echo_value;

  // frame state
  logic [6:0]  byte_counter;
  logic [7:0]  crc_low_seen;
  logic [7:0]  high_byte_hold;
  logic        frame_bad;
  logic        frame_done;
  logic [1:0]  verdict;
  logic [5:0]  word_idx;

  logic                  accept;
  logic                  slot_free;
  logic                  out_load;
  logic                  rd_mode;
  logic                  count_ok;
  logic [7:0]            p_ext;
  logic [7:0]            frame_len;
  logic                  at_final;
  logic                  at_crc_low;
  logic                  crc_match;
  logic                  frame_ok;
  logic [7:0]            expect_byte;
  logic                  check_en;
  logic [6:0]            data_pos;
  logic                  st_wr_en;
  logic [AW-1:0]         st_wr_addr;
  logic [AW-1:0]         st_rd_addr;
  logic [15:0]           st_rd_data;
  rtuchk_pkg::crc_ctrl_t crc_ctrl;
  logic [15:0]           crc_value;
  logic                  crc_busy;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign out_load  = ((state == S_WORD) || (state == S_VERDICT)) && slot_free;
  assign rd_mode   = !transaction_mode;
  assign count_ok  = (reg_count != 6'd0) && (32'(reg_count) <= MAX_REGS);

  always_comb begin
    p_ext      = {1'b0, byte_counter};
    frame_len  = rd_mode ? (8'd5 + {1'b0, reg_count, 1'b0}) : 8'd8;
    at_final   = p_ext >= (frame_len - 8'd1);
    at_crc_low = p_ext == (frame_len - 8'd2);
    crc_match  = {rx_byte, crc_low_seen} == crc_value;
    frame_ok   = !frame_bad && (p_ext == (frame_len - 8'd1)) && crc_match;
    data_pos   = byte_counter - 7'd3;

    expect_byte = device_addr;
    check_en    = 1'b1;
    if (byte_counter == 7'd0) begin
      expect_byte = device_addr;
    end else if (byte_counter == 7'd1) begin
      expect_byte = rd_mode ? rtuchk_pkg::FC_READ : rtuchk_pkg::FC_WRITE;
    end else if (rd_mode) begin
      expect_byte = {1'b0, reg_count, 1'b0};
      check_en    = (byte_counter == 7'd2);
    end else begin
      case (byte_counter)
        7'd2:    expect_byte = echo_address[15:8];
        7'd3:    expect_byte = echo_address[7:0];
        7'd4:    expect_byte = echo_value[15:8];
        default: expect_byte = echo_value[7:0];
      endcase
    end
  end

  // the byte path that folds into the CRC (neither CRC byte)
  logic byte_live;
  logic body_byte;
  assign byte_live = accept && (func == rtuchk_pkg::FUNC_BYTE) && !frame_done &&
                     !(rd_mode && !count_ok);
  assign body_byte = byte_live && !at_final && !at_crc_low;

  always_comb begin
    crc_ctrl.clear = accept && (func == rtuchk_pkg::FUNC_START);
    crc_ctrl.load  = body_byte;
  end

  assign st_wr_en   = body_byte && rd_mode && (byte_counter >= 7'd3) && data_pos[0] &&
                      (32'(data_pos[6:1]) < MAX_REGS);
  assign st_wr_addr = AW'(data_pos[6:1]);
  assign st_rd_addr = AW'(word_idx);

  rtuchk_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .data (rx_byte),
    .crc  (crc_value),
    .busy (crc_busy)
  );

  rtuchk_store #(
    .DEPTH (MAX_REGS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data ({high_byte_hold, rx_byte}),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      device_addr      <= 8'd1;
      transaction_mode <= 1'b0;
      reg_count        <= 6'd1;
      echo_address     <= 16'd0;
      echo_value       <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rtuchk_pkg::CFG_DEVICE_ADDR:  device_addr      <= cfg_data[7:0];
        rtuchk_pkg::CFG_MODE:         transaction_mode <= cfg_data[0];
        rtuchk_pkg::CFG_REG_COUNT:    reg_count        <= cfg_data[5:0];
        rtuchk_pkg::CFG_ECHO_ADDRESS: echo_address     <= cfg_data;
        rtuchk_pkg::CFG_ECHO_VALUE:   echo_value       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      byte_counter   <= 7'd0;
      crc_low_seen   <= 8'd0;
      high_byte_hold <= 8'd0;
      frame_bad      <= 1'b0;
      frame_done     <= 1'b1;
      out_valid      <= 1'b0;
      verdict        <= rtuchk_pkg::ST_REJECT;
      word_idx       <= 6'd0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (func)
              rtuchk_pkg::FUNC_START: begin
                byte_counter   <= 7'd0;
                crc_low_seen   <= 8'd0;
                high_byte_hold <= 8'd0;
                frame_bad      <= 1'b0;
                frame_done     <= rd_mode && !count_ok;
                if (rd_mode && !count_ok) begin
                  verdict    <= rtuchk_pkg::ST_REJECT;
                  state      <= S_VERDICT;
                end
              end
              rtuchk_pkg::FUNC_TIMEOUT: begin
                if (!frame_done) begin
                  frame_done <= 1'b1;
                  verdict    <= rtuchk_pkg::ST_TIMEOUT;
                  state      <= S_VERDICT;
                end
              end
              rtuchk_pkg::FUNC_BYTE: begin
                if (!frame_done) begin
                  if (rd_mode && !count_ok) begin
                    frame_done <= 1'b1;
                    verdict    <= rtuchk_pkg::ST_REJECT;
                    state      <= S_VERDICT;
                  end else begin
                    if (byte_counter != 7'd127) begin
                      byte_counter <= byte_counter + 7'd1;
                    end
                    if (at_final) begin
                      frame_done <= 1'b1;
                      if (frame_ok && rd_mode) begin
                        word_idx <= 6'd0;
                        state    <= S_FETCH;
                      end else begin
                        verdict <= frame_ok ? rtuchk_pkg::ST_ACCEPT : rtuchk_pkg::ST_REJECT;
                        state   <= S_VERDICT;
                      end
                    end else if (at_crc_low) begin
                      crc_low_seen <= rx_byte;
                    end else begin
                      state <= S_CRC;
                      if (check_en && (rx_byte != expect_byte)) begin
                        frame_bad <= 1'b1;
                      end
                      if (rd_mode && (byte_counter >= 7'd3) && !data_pos[0]) begin
                        high_byte_hold <= rx_byte;
                      end
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_CRC: begin
          if (!crc_busy) begin
            state <= S_IDLE;
          end
        end
        S_FETCH: begin
          state <= S_WORD;
        end
        S_WORD: begin
          if (slot_free) begin
            status    <= rtuchk_pkg::ST_WORD;
            reg_index <= word_idx[4:0];
            reg_value <= st_rd_data;
            last      <= 1'b0;
            if (6'(word_idx + 6'd1) == reg_count) begin
              verdict <= rtuchk_pkg::ST_ACCEPT;
              state   <= S_VERDICT;
            end else begin
              word_idx <= word_idx + 6'd1;
              state    <= S_FETCH;
            end
          end
        end
        S_VERDICT: begin
          if (slot_free) begin
            status    <= verdict;
            reg_index <= 5'd0;
            reg_value <= 16'd0;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_take_while_crc: assert property (@(posedge clk) disable iff (rst)
    crc_busy |-> !in_ready)
    else $error("request taken while crc running");

  a_word_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_WORD && slot_free) |=>
      (out_valid && status == rtuchk_pkg::ST_WORD && !last))
    else $error("word not loaded into output");

  a_word_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (status == rtuchk_pkg::ST_WORD))
    else $error("verdict without last");

endmodule
